// ----- rtl/core/fixed_frame_xor_parser_top_macros.svh -----
// Assertion macros shared by the frame parser RTL.
// Standalone header; the including module supplies clock and reset names.
`ifndef FIXED_FRAME_XOR_PARSER_TOP_MACROS_SVH
`define FIXED_FRAME_XOR_PARSER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFXP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FFXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ffxp_pkg.sv -----
// Types and constants for the fixed-length frame parser.
// No dependencies; imported by the channel interfaces and the top level.
package ffxp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ERROR_W     = 16;
   localparam int unsigned POS_W       = 3;
   localparam int unsigned CSR_INDEX_W = 4;

   // Frame bytes 2 to 6 are kept; byte 7 (the checksum) is compared on arrival.
   localparam int unsigned STORE_DEPTH = 5;
   localparam int unsigned STORE_IDX_W = 3;

   localparam logic [POS_W-1:0] POS_HEADER_FIRST  = 3'd0;
   localparam logic [POS_W-1:0] POS_HEADER_SECOND = 3'd1;
   localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = 3'd2;
   localparam logic [POS_W-1:0] POS_CHECKSUM      = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FIRST  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SECOND = 4'd1;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'h55;

   // Control byte bits.
   localparam int unsigned CTRL_VALID_BIT = 0;
   localparam int unsigned CTRL_STOP_BIT  = 1;

   typedef enum logic [2:0] {
      ST_ACCEPTED     = 3'd0,
      ST_HEADER_ERR   = 3'd1,
      ST_CHECKSUM_ERR = 3'd2,
      ST_NO_MEAS      = 3'd3,
      ST_VALID        = 3'd4
   } status_type;

endpackage

// ----- rtl/core/ffxp_ifs.sv -----
// Valid/ready channel interfaces of the frame parser: byte input, result
// output and register write. Depends on ffxp_pkg.
interface ffxp_req_if import ffxp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffxp_rsp_if import ffxp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [ERROR_W-1:0] error_x;
   logic signed [ERROR_W-1:0] error_y;

   modport source (output valid, output status, output error_x, output error_y,
                   input ready);
   modport sink   (input valid, input status, input error_x, input error_y,
                   output ready);
endinterface

interface ffxp_csr_if import ffxp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [BYTE_W-1:0]      wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/core/fixed_frame_xor_parser_top.sv -----
// Fixed-length frame parser with two header bytes and an XOR checksum.
// Depends on ffxp_pkg, the channel interfaces and the assertion macros.
//
// Usage: every received byte is one transaction on req_ch and yields exactly
// one result transaction on rsp_ch. Frames are eight bytes: two header bytes,
// a control byte, error X and error Y (little-endian signed 16 bit) and an
// XOR checksum over bytes 2 to 6. Bytes inside a frame report "accepted";
// the checksum byte reports checksum error, no measurement or a valid frame
// with X and Y. Wrong header bytes report a header error.
// csr_ch writes header_first (index 0) and header_second (index 1); it is
// always ready, and other indexes are ignored.
// Pipeline: a byte accepted on req_ch is captured in the input register, is
// parsed there, and its result is written to the result register that drives
// rsp_ch. Throughput is one byte per cycle while rsp_ch does not stall, set
// by the input register and the result register each taking one byte.
// When rsp_ch stalls, the result register holds and the input register
// fills; req_ch.ready then drops until the result is taken.
// Reset clears the pipeline, restores the header registers to 0xAA and 0x55
// and returns the parser to waiting for the first header byte.
`include "fixed_frame_xor_parser_top_macros.svh"

module fixed_frame_xor_parser_top import ffxp_pkg::*; (
   input logic         clock,
   input logic         reset,
   ffxp_req_if.sink    req_ch,
   ffxp_rsp_if.source  rsp_ch,
   ffxp_csr_if.sink    csr_ch
);

   logic [BYTE_W-1:0] header_first_ff;
   logic [BYTE_W-1:0] header_second_ff;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] store_ff [STORE_DEPTH];

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, status_in;
   logic signed [ERROR_W-1:0] rsp_x_ff, x_in;
   logic signed [ERROR_W-1:0] rsp_y_ff, y_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   advance;
   logic                   store_we;
   logic [STORE_IDX_W-1:0] store_idx;
   logic [BYTE_W-1:0]      checksum;
   logic [BYTE_W-1:0]      ctrl;

   // Register writes.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            REG_HEADER_FIRST:  header_first_ff  <= csr_ch.wdata;
            REG_HEADER_SECOND: header_second_ff <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   // Parsing of the byte in the input register.
   assign ctrl      = store_ff[0];
   assign checksum  = store_ff[0] ^ store_ff[1] ^ store_ff[2] ^ store_ff[3] ^ store_ff[4];
   assign store_idx = STORE_IDX_W'(pos_ff - POS_FIRST_PAYLOAD);
   assign store_we  = advance && (pos_ff >= POS_FIRST_PAYLOAD) && (pos_ff != POS_CHECKSUM);

   always_comb begin
      pos_in    = pos_ff;
      status_in = ST_ACCEPTED;
      x_in      = '0;
      y_in      = '0;
      priority if (pos_ff == POS_HEADER_FIRST) begin
         if (in_byte_ff == header_first_ff) begin
            pos_in = POS_HEADER_SECOND;
         end else begin
            status_in = ST_HEADER_ERR;
         end
      end else if (pos_ff == POS_HEADER_SECOND) begin
         if (in_byte_ff == header_second_ff) begin
            pos_in = POS_FIRST_PAYLOAD;
         end else begin
            // A repeated first header byte may be the start of the next frame.
            status_in = ST_HEADER_ERR;
            pos_in    = (in_byte_ff == header_first_ff) ? POS_HEADER_SECOND
                                                        : POS_HEADER_FIRST;
         end
      end else if (pos_ff == POS_CHECKSUM) begin
         pos_in = POS_HEADER_FIRST;
         if (checksum != in_byte_ff) begin
            status_in = ST_CHECKSUM_ERR;
         end else if (!ctrl[CTRL_VALID_BIT] || ctrl[CTRL_STOP_BIT]) begin
            status_in = ST_NO_MEAS;
         end else begin
            status_in = ST_VALID;
            x_in      = {store_ff[2], store_ff[1]};
            y_in      = {store_ff[4], store_ff[3]};
         end
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_HEADER_FIRST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_x_ff      <= x_in;
         rsp_y_ff      <= y_in;
      end
      if (store_we) begin
         store_ff[store_idx] <= in_byte_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.error_x = rsp_x_ff;
   assign rsp_ch.error_y = rsp_y_ff;

   `FFXP_ASSERT_SAME(a_errors_zero_unless_valid, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_VALID),
      (rsp_x_ff == '0) && (rsp_y_ff == '0), "error fields set on a non-valid result")
   `FFXP_ASSERT_NEXT(a_frame_end_restarts, clock, reset,
      advance && (pos_ff == POS_CHECKSUM),
      pos_ff == POS_HEADER_FIRST, "parser did not restart after the checksum byte")
   `FFXP_ASSERT_NEXT(a_pos_holds_when_stalled, clock, reset,
      !advance, $stable(pos_ff), "byte position moved without a byte being parsed")
   `FFXP_ASSERT_NEXT(a_stalled_byte_kept, clock, reset,
      in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff), "stalled input byte was lost")

endmodule
